### design/cht_pkg.sv
package cht_pkg;

	// default geometry
	localparam int BUCKET_COUNT_DEF = 256;
	localparam int ENTRY_COUNT_DEF  = 1024;

	// item field widths
	localparam int OP_W        = 2;
	localparam int HASH_W      = 32;
	localparam int KEY_W       = 64;
	localparam int STATUS_W    = 3;
	localparam int SLOT_OUT_W  = 10;
	localparam int LIVE_OUT_W  = 11;
	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 24;

	// request kinds
	localparam logic [OP_W-1:0] OP_GET    = 2'd0;
	localparam logic [OP_W-1:0] OP_PUT    = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND    = 3'd0,
		ST_INSERTED = 3'd1,
		ST_REMOVED  = 3'd2,
		ST_MISSING  = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HEAD,
		S_CHECK,
		S_CMP,
		S_DECIDE,
		S_INS_FREE,
		S_UNLINK,
		S_RELEASE,
		S_FIN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    load_req;
		logic    start_walk;
		logic    rd_entry;
		logic    match_hit;
		logic    advance;
		logic    rd_free;
		logic    ins_free;
		logic    ins_new;
		logic    unlink;
		logic    release_slot;
		logic    set_res;
		status_t res_code;
		logic    load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            cur_ok;
		logic            walk_done;
		logic            match;
		logic            hit;
		logic            free_ok;
		logic            room;
		logic            out_free;
	} stat_t;

endpackage

### design/cht_ctrl.sv
module cht_ctrl
	import cht_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_HEAD;
			end
			S_HEAD: state_d = S_CHECK;
			S_CHECK: begin
				if (stat.cur_ok && !stat.walk_done) state_d = S_CMP;
				else state_d = S_DECIDE;
			end
			S_CMP: begin
				if (stat.match) state_d = S_DECIDE;
				else state_d = S_CHECK;
			end
			S_DECIDE: begin
				case (stat.op)
					OP_PUT: begin
						if (stat.hit) state_d = S_FIN;
						else if (stat.free_ok) state_d = S_INS_FREE;
						else state_d = S_FIN;
					end
					OP_REMOVE: begin
						if (stat.hit) state_d = S_UNLINK;
						else state_d = S_FIN;
					end
					default: state_d = S_FIN;
				endcase
			end
			S_INS_FREE: state_d = S_FIN;
			S_UNLINK:   state_d = S_RELEASE;
			S_RELEASE:  state_d = S_FIN;
			S_FIN: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		cmd.res_code = ST_MISSING;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load_req = in_valid;
			end
			S_HEAD: cmd.start_walk = 1'b1;
			S_CHECK: begin
				if (stat.cur_ok && !stat.walk_done) cmd.rd_entry = 1'b1;
			end
			S_CMP: begin
				if (stat.match) cmd.match_hit = 1'b1;
				else cmd.advance = 1'b1;
			end
			S_DECIDE: begin
				case (stat.op)
					OP_PUT: begin
						if (stat.hit) begin
							cmd.set_res  = 1'b1;
							cmd.res_code = ST_FOUND;
						end else if (stat.free_ok) begin
							cmd.rd_free = 1'b1;
						end else if (stat.room) begin
							cmd.ins_new = 1'b1;
						end else begin
							cmd.set_res  = 1'b1;
							cmd.res_code = ST_FULL;
						end
					end
					OP_REMOVE: begin
						if (!stat.hit) begin
							cmd.set_res  = 1'b1;
							cmd.res_code = ST_MISSING;
						end
					end
					default: begin
						cmd.set_res  = 1'b1;
						cmd.res_code = stat.hit ? ST_FOUND : ST_MISSING;
					end
				endcase
			end
			S_INS_FREE: cmd.ins_free = 1'b1;
			S_UNLINK:   cmd.unlink = 1'b1;
			S_RELEASE: begin
				cmd.release_slot = 1'b1;
				cmd.set_res      = 1'b1;
				cmd.res_code     = ST_REMOVED;
			end
			S_FIN: cmd.load_out = stat.out_free;
			default: ;
		endcase
	end

endmodule

### design/cht_dp.sv
module cht_dp
	import cht_pkg::*;
#(
	parameter int BUCKET_COUNT = BUCKET_COUNT_DEF,
	parameter int ENTRY_COUNT  = ENTRY_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [OP_W-1:0]        in_op,
	input  logic [HASH_W-1:0]      in_hash,
	input  logic [KEY_W-1:0]       in_key,
	input  cmd_t                   cmd,
	output stat_t                  stat,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [STATUS_W-1:0]    out_status,
	output logic [SLOT_OUT_W-1:0]  out_slot,
	output logic [LIVE_OUT_W-1:0]  out_live
);

	localparam int LINK_W = $clog2(ENTRY_COUNT + 1);
	localparam int SLOT_W = $clog2(ENTRY_COUNT);
	localparam int BKT_W  = $clog2(BUCKET_COUNT);
	localparam int ENT_W  = HASH_W + KEY_W;
	localparam logic [LINK_W-1:0] ENTRY_LIM = LINK_W'(ENTRY_COUNT);

	// memories: chain heads, entry hash and key, entry links
	logic [LINK_W-1:0] head_mem [BUCKET_COUNT];
	logic [ENT_W-1:0]  entry_mem [ENTRY_COUNT];
	logic [LINK_W-1:0] link_mem [ENTRY_COUNT];
	logic [BUCKET_COUNT-1:0] head_vld_q;

	logic [OP_W-1:0]   op_q;
	logic [HASH_W-1:0] hash_q;
	logic [KEY_W-1:0]  key_q;
	logic [BKT_W-1:0]  bkt_q;
	logic [LINK_W-1:0] head_rd_q;
	logic              head_vld_rd_q;
	logic [LINK_W-1:0] head_q;
	logic [LINK_W-1:0] cur_q;
	logic [LINK_W-1:0] prev_q;
	logic [LINK_W-1:0] nxt_q;
	logic [LINK_W-1:0] steps_q;
	logic              hit_q;
	logic [ENT_W-1:0]  entry_rd_q;
	logic [LINK_W-1:0] link_rd_q;
	logic [LINK_W-1:0] free_q;
	logic [LINK_W-1:0] hw_q;
	logic [LINK_W-1:0] live_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic [LINK_W-1:0]   out_live_q;

	logic [SLOT_W-1:0] cur_slot;
	logic [SLOT_W-1:0] free_slot;
	logic [SLOT_W-1:0] ins_slot;
	logic              ins;
	logic              free_ok;
	logic              link_we;
	logic              link_re;
	logic [SLOT_W-1:0] link_addr;
	logic [LINK_W-1:0] link_wdata;
	logic              head_we;
	logic [LINK_W-1:0] head_wdata;

	assign cur_slot  = SLOT_W'(cur_q - LINK_W'(1));
	assign free_slot = SLOT_W'(free_q - LINK_W'(1));
	assign ins       = cmd.ins_free || cmd.ins_new;
	assign ins_slot  = cmd.ins_free ? free_slot : SLOT_W'(hw_q);
	assign free_ok   = (free_q != '0) && (free_q <= ENTRY_LIM);

	// status toward the controller
	always_comb begin
		stat.op        = op_q;
		stat.cur_ok    = (cur_q != '0) && (cur_q <= ENTRY_LIM);
		stat.walk_done = (steps_q == ENTRY_LIM);
		stat.match     = (entry_rd_q == {hash_q, key_q});
		stat.hit       = hit_q;
		stat.free_ok   = free_ok;
		stat.room      = (hw_q < ENTRY_LIM);
		stat.out_free  = !out_valid_q || out_ready;
	end

	// link memory port selection
	always_comb begin
		link_we    = 1'b0;
		link_re    = 1'b0;
		link_addr  = cur_slot;
		link_wdata = nxt_q;
		if (cmd.rd_entry) begin
			link_re = 1'b1;
		end else if (cmd.rd_free) begin
			link_re   = 1'b1;
			link_addr = free_slot;
		end else if (ins) begin
			link_we    = 1'b1;
			link_addr  = ins_slot;
			link_wdata = head_q;
		end else if (cmd.unlink && prev_q != '0) begin
			link_we   = 1'b1;
			link_addr = SLOT_W'(prev_q - LINK_W'(1));
		end else if (cmd.release_slot) begin
			link_we    = 1'b1;
			link_wdata = free_q;
		end
	end

	// head memory write selection
	always_comb begin
		head_we    = 1'b0;
		head_wdata = nxt_q;
		if (ins) begin
			head_we    = 1'b1;
			head_wdata = LINK_W'(ins_slot) + LINK_W'(1);
		end else if (cmd.unlink && prev_q == '0) begin
			head_we = 1'b1;
		end
	end

	// head memory
	always_ff @(posedge clk) begin
		if (head_we) head_mem[bkt_q] <= head_wdata;
		if (cmd.load_req) head_rd_q <= head_mem[in_hash[BKT_W-1:0]];
	end

	// head valid bits and their read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q    <= '0;
			head_vld_rd_q <= 1'b0;
		end else begin
			if (head_we) head_vld_q[bkt_q] <= 1'b1;
			if (cmd.load_req) head_vld_rd_q <= head_vld_q[in_hash[BKT_W-1:0]];
		end
	end

	// entry hash and key memory
	always_ff @(posedge clk) begin
		if (ins) entry_mem[ins_slot] <= {hash_q, key_q};
		else if (cmd.rd_entry) entry_rd_q <= entry_mem[cur_slot];
	end

	// link memory
	always_ff @(posedge clk) begin
		if (link_we) link_mem[link_addr] <= link_wdata;
		else if (link_re) link_rd_q <= link_mem[link_addr];
	end

	// request and walk registers
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q   <= in_op;
			hash_q <= in_hash;
			key_q  <= in_key;
			bkt_q  <= in_hash[BKT_W-1:0];
		end
		if (cmd.start_walk) begin
			head_q  <= head_vld_rd_q ? head_rd_q : '0;
			cur_q   <= head_vld_rd_q ? head_rd_q : '0;
			prev_q  <= '0;
			steps_q <= '0;
		end else if (cmd.advance) begin
			prev_q  <= cur_q;
			cur_q   <= link_rd_q;
			steps_q <= steps_q + LINK_W'(1);
		end
		if (cmd.match_hit) nxt_q <= link_rd_q;
		if (cmd.set_res) begin
			res_status_q <= cmd.res_code;
			res_slot_q   <= (cmd.res_code == ST_FOUND || cmd.res_code == ST_REMOVED)
				? cur_slot : '0;
		end else if (ins) begin
			res_status_q <= ST_INSERTED;
			res_slot_q   <= ins_slot;
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_live_q   <= live_q;
		end
	end

	// table bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q       <= 1'b0;
			free_q      <= '0;
			hw_q        <= '0;
			live_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start_walk) hit_q <= 1'b0;
			else if (cmd.match_hit) hit_q <= 1'b1;
			if (cmd.ins_free) free_q <= link_rd_q;
			else if (cmd.release_slot) free_q <= cur_q;
			if (cmd.ins_new) hw_q <= hw_q + LINK_W'(1);
			if (ins) live_q <= live_q + LINK_W'(1);
			else if (cmd.release_slot && live_q != '0) live_q <= live_q - LINK_W'(1);
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_slot   = SLOT_OUT_W'(out_slot_q);
	assign out_live   = LIVE_OUT_W'(out_live_q);

endmodule

### design/chained_hash_table_top.sv
// channel   | dir | tdata fields (lsb first)            | bits
// s_axis    | in  | op[1:0] hash[33:2] key[97:34]       | 104
// m_axis    | out | status[2:0] slot[12:3] live[23:13]  | 24
//
// one item at a time: accept it and read the bucket head, then read and compare
// each chain entry in turn, check once more when the walk runs off the end of the
// chain, decide, update links where needed and load the result.
// reset clears the bucket valid bits at once, no clearing pass is needed.
// a result waits in the output register; a stalled m_axis holds the next item
// only at its final step. BUCKET_COUNT must be a power of two.
module chained_hash_table_top
	import cht_pkg::*;
#(
	parameter int BUCKET_COUNT = BUCKET_COUNT_DEF,
	parameter int ENTRY_COUNT  = ENTRY_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // op, hash, key
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // status, slot, live_count
);

	cmd_t  cmd;
	stat_t stat;
	logic [STATUS_W-1:0]   status;
	logic [SLOT_OUT_W-1:0] slot;
	logic [LIVE_OUT_W-1:0] live_count;

	cht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cht_dp #(
		.BUCKET_COUNT (BUCKET_COUNT),
		.ENTRY_COUNT  (ENTRY_COUNT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_op      (s_axis_tdata[1:0]),
		.in_hash    (s_axis_tdata[33:2]),
		.in_key     (s_axis_tdata[97:34]),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (status),
		.out_slot   (slot),
		.out_live   (live_count)
	);

	assign m_axis_tdata = {live_count, slot, status};

endmodule

### design/cht_check.sv
module cht_check
	import cht_pkg::*;
#(
	parameter int ENTRY_COUNT = ENTRY_COUNT_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// one item at a time: input closes after an accept
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted back to back");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// status is a known code
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:0] <= ST_FULL)
		else $error("bad status code");

	// misses and full report slot zero
	a_noslot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[2:0] == ST_MISSING || m_axis_tdata[2:0] == ST_FULL)
		|-> m_axis_tdata[12:3] == '0)
		else $error("slot not zero on miss");

	// live count within table size, nonzero after insert
	a_live: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[23:13] <= LIVE_OUT_W'(ENTRY_COUNT)) &&
		(m_axis_tdata[2:0] != ST_INSERTED || m_axis_tdata[23:13] != '0))
		else $error("live count out of range");

endmodule

bind chained_hash_table_top cht_check #(.ENTRY_COUNT(ENTRY_COUNT)) u_cht_check (.*);

### tb/sv/chained_hash_table_top_tb.sv
module chained_hash_table_top_tb;
	import cht_pkg::*;

	localparam int NBUCKET = BUCKET_COUNT_DEF;
	localparam int NENTRY  = ENTRY_COUNT_DEF;
	localparam int CYCLE_LIMIT = 20000000;
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic [LIVE_OUT_W-1:0] live;
		logic [SLOT_OUT_W-1:0] slot;
		status_t               status;
	} answer_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	chained_hash_table_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// table shadow state
	int unsigned       head_lnk [NBUCKET];
	logic [HASH_W-1:0] slot_hash [NENTRY];
	logic [KEY_W-1:0]  slot_key [NENTRY];
	int unsigned       slot_lnk [NENTRY];
	bit                slot_live [NENTRY];
	int unsigned       free_lnk;
	int unsigned       live_total;
	int unsigned       fresh_mark;

	answer_t     pending_answers [$];
	int          error_count;
	int unsigned cycle_count;
	bit          quiet_mode;
	int          hold_cycles;
	bit          long_hold;

	// recent keys for reuse
	logic [HASH_W-1:0] used_hash [$];
	logic [KEY_W-1:0]  used_key [$];

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// update the shadow table and return the answer for one request
	function automatic answer_t lookup_update(logic [OP_W-1:0] op, logic [HASH_W-1:0] h,
		logic [KEY_W-1:0] k);
		int unsigned b, cur, prev, hit, steps, s;
		answer_t a;
		b = h % NBUCKET;
		cur = head_lnk[b];
		prev = 0;
		hit = 0;
		for (steps = 0; steps < NENTRY; steps++) begin
			if (cur < 1 || cur > NENTRY) break;
			s = cur - 1;
			if (slot_live[s] && slot_hash[s] == h && slot_key[s] == k) begin
				hit = cur;
				break;
			end
			prev = cur;
			cur = slot_lnk[s];
		end
		if (hit == 0) prev = 0;
		a.status = ST_MISSING;
		s = 0;
		if (op == OP_PUT) begin
			if (hit != 0) begin
				a.status = ST_FOUND;
				s = hit - 1;
			end else if (free_lnk >= 1 && free_lnk <= NENTRY || fresh_mark < NENTRY) begin
				if (free_lnk >= 1 && free_lnk <= NENTRY) begin
					s = free_lnk - 1;
					free_lnk = slot_lnk[s];
				end else begin
					s = fresh_mark;
					fresh_mark++;
				end
				slot_hash[s] = h;
				slot_key[s] = k;
				slot_live[s] = 1'b1;
				slot_lnk[s] = head_lnk[b];
				head_lnk[b] = s + 1;
				live_total++;
				a.status = ST_INSERTED;
			end else begin
				a.status = ST_FULL;
			end
		end else if (op == OP_REMOVE) begin
			if (hit != 0) begin
				s = hit - 1;
				if (prev == 0) head_lnk[b] = slot_lnk[s];
				else slot_lnk[prev - 1] = slot_lnk[s];
				slot_live[s] = 1'b0;
				slot_lnk[s] = free_lnk;
				free_lnk = hit;
				if (live_total > 0) live_total--;
				a.status = ST_REMOVED;
			end
		end else if (hit != 0) begin
			a.status = ST_FOUND;
			s = hit - 1;
		end
		a.slot = s[SLOT_OUT_W-1:0];
		a.live = live_total[LIVE_OUT_W-1:0];
		return a;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		error_count++;
		$display("mismatch %s: got %0d expected %0d", what, got, want);
	endtask

	// send one request, predicting its answer when accepted
	task automatic send_request(logic [OP_W-1:0] op, logic [HASH_W-1:0] h,
		logic [KEY_W-1:0] k);
		int gap;
		if (!quiet_mode && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_TDATA_W'({k, h, op});
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_answers.push_back(lookup_update(op, h, k));
		if (used_hash.size() < 64 && op == OP_PUT) begin
			used_hash.push_back(h);
			used_key.push_back(k);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		answer_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected item", 1, 0);
			end else begin
				want = pending_answers.pop_front();
				if (got.status !== want.status)
					report_mismatch("status", got.status, want.status);
				if (got.slot !== want.slot) report_mismatch("slot", got.slot, want.slot);
				if (got.live !== want.live) report_mismatch("live_count", got.live, want.live);
			end
		end
	end

	// receiver stalls, with a long hold on request
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (long_hold) begin
			m_axis_tready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
			hold_cycles <= $urandom_range(0, 7);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [KEY_W-1:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	task automatic test_directed();
		send_request(OP_GET, 32'h0, 64'h0);
		send_request(OP_REMOVE, 32'h0, 64'h0);
		send_request(OP_PUT, 32'h0, 64'h0);
		send_request(OP_PUT, 32'h0, 64'h0);
		send_request(OP_PUT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(OP_PUT, 32'h0000_0100, 64'h0);
		send_request(OP_PUT, 32'h0, 64'h1);
		send_request(OP_GET, 32'h0, 64'h1);
		send_request(OP_GET, 32'h0000_0100, 64'h0);
		send_request(OP_SPARE, 32'h0, 64'h0);
		send_request(OP_REMOVE, 32'h0, 64'h0);
		send_request(OP_GET, 32'h0, 64'h0);
		send_request(OP_REMOVE, 32'h0000_0100, 64'h0);
		send_request(OP_PUT, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(OP_PUT, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555);
		send_request(OP_REMOVE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(OP_SPARE, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
	endtask

	// mixed traffic over few buckets to build long chains
	task automatic test_random(int count);
		int i, pick;
		logic [OP_W-1:0] op;
		logic [HASH_W-1:0] h;
		logic [KEY_W-1:0] k;
		for (i = 0; i < count; i++) begin
			pick = $urandom_range(0, 9);
			op = (pick < 4) ? OP_PUT : (pick < 7) ? OP_GET : (pick < 9) ? OP_REMOVE : OP_SPARE;
			if (used_hash.size() > 0 && $urandom_range(0, 1)) begin
				pick = $urandom_range(0, used_hash.size() - 1);
				h = used_hash[pick];
				k = used_key[pick];
				if ($urandom_range(0, 7) == 0) k[0] = ~k[0];
			end else begin
				h = $urandom;
				if ($urandom_range(0, 1)) h[7:0] = 8'($urandom_range(0, 3));
				k = ($urandom_range(0, 1)) ? rand_key() : {62'd0, 2'(h)};
			end
			send_request(op, h, k);
		end
	endtask

	// long receiver hold while the sender keeps offering
	task automatic test_backpressure();
		fork
			begin
				long_hold <= 1'b1;
				repeat (300) @(posedge clk);
				long_hold <= 1'b0;
			end
		join_none
		test_random(40);
	endtask

	// fill the table past capacity, then try one remove and more puts
	task automatic test_full_table();
		int i, fill;
		fill = NENTRY + 4 - int'(live_total);
		for (i = 0; i < fill; i++)
			send_request(OP_PUT, $urandom, rand_key());
		send_request(OP_PUT, 32'h1234_5678, 64'h9);
		send_request(OP_REMOVE, 32'h0000_0100, 64'h0);
		send_request(OP_PUT, 32'h1234_5678, 64'h9);
		send_request(OP_PUT, 32'h1234_5679, 64'h9);
	endtask

	initial begin
		int wait_cycles;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		error_count = 0;
		cycle_count = 0;
		quiet_mode = 1'b0;
		hold_cycles = 0;
		long_hold = 1'b0;
		free_lnk = 0;
		live_total = 0;
		fresh_mark = 0;
		foreach (head_lnk[i]) head_lnk[i] = 0;
		foreach (slot_live[i]) begin
			slot_live[i] = 1'b0;
			slot_lnk[i] = 0;
			slot_hash[i] = '0;
			slot_key[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(120);
		test_backpressure();
		test_random(40);
		test_full_table();
		quiet_mode = 1'b1;
		test_random(60);
		s_axis_tvalid <= 1'b0;
		wait_cycles = 0;
		while (pending_answers.size() > 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (100) @(posedge clk);
		if (error_count == 0 && pending_answers.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
